// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define IKST_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("ikst assertion failed");

// Check that a condition implies another in the next cycle.
`define IKST_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("ikst assertion failed");

`endif

// ===== sv/ikst_pkg.sv =====
package ikst_pkg;

    // Fixed field widths of the request and response
    localparam int KEY_W    = 64;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_PRESENT  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_PENDING  = 3'd5,
        ST_SKIPPED  = 3'd6
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== sv/ikst_if.sv =====
interface ikst_req_if;
    logic                          valid;
    logic                          ready;
    logic [ikst_pkg::ACTION_W-1:0] action;
    logic [ikst_pkg::KEY_W-1:0]    key;
    logic                          key_valid;
    logic                          last;

    modport source (output valid, action, key, key_valid, last, input ready);
    modport sink (input valid, action, key, key_valid, last, output ready);
endinterface

interface ikst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ikst_pkg::STATUS_W-1:0] status;
    logic [ikst_pkg::KEY_W-1:0]    conflict_key;
    logic                          done_res;
    logic [ikst_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, conflict_key, done_res, occupancy, input ready);
    modport sink (input valid, status, conflict_key, done_res, occupancy, output ready);
endinterface

// ===== sv/inflight_key_set_tracker.sv =====
// A request's key is compared against every CAM row when it is captured;
// an update step then picks the lowest free or matching row, held off while
// the output register holds a result not yet taken; a new request is taken only after that step.
// The next request is taken while a finished result waits in the output register.
// Reset (synchronous, active low) empties the set, closes any batch and zeroes
// the count; key rows are not cleared and need no clearing pass.
module inflight_key_set_tracker #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ikst_req_if.sink   i_req,
    ikst_rsp_if.source o_rsp
);

    ikst_pkg::t_ctl_cmd cmd;
    ikst_pkg::t_dp_stat stat;

    ikst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ikst_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_action       (i_req.action),
        .i_key          (i_req.key),
        .i_key_valid    (i_req.key_valid),
        .i_last         (i_req.last),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_conflict_key (o_rsp.conflict_key),
        .o_done_res     (o_rsp.done_res),
        .o_occupancy    (o_rsp.occupancy)
    );

endmodule

// ===== sv/ikst_ctrl.sv =====
`include "assert_macros.svh"

module ikst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ikst_pkg::t_dp_stat i_stat,
    output ikst_pkg::t_ctl_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take a request only between items
    assign o_in_ready = (r_state == S_IDLE);

    // Issue capture on accept, execute once the output slot is free
    always_comb begin
        o_cmd.capture = i_in_valid && (r_state == S_IDLE);
        o_cmd.execute = (r_state == S_EXEC) && i_stat.out_free;
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `IKST_ASSERT_NEXT(a_hold_exec, i_clk, i_rst_n, r_state == S_EXEC && !i_stat.out_free, r_state == S_EXEC)
    `IKST_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, o_cmd.capture, r_state == S_EXEC)

endmodule

// ===== sv/ikst_dp.sv =====
`include "assert_macros.svh"

module ikst_dp #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ikst_pkg::t_ctl_cmd              i_cmd,
    output ikst_pkg::t_dp_stat              o_stat,
    input  logic [ikst_pkg::ACTION_W-1:0]   i_action,
    input  logic [ikst_pkg::KEY_W-1:0]      i_key,
    input  logic                            i_key_valid,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ikst_pkg::STATUS_W-1:0]   o_status,
    output logic [ikst_pkg::KEY_W-1:0]      o_conflict_key,
    output logic                            o_done_res,
    output logic [ikst_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        K_NONE,
        K_INSERT,
        K_REMOVE
    } t_kind;

    // Key store: one register row per entry, each with its own comparator
    logic [KEY_BITS-1:0] r_keys [ENTRIES];

    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  r_staged;
    ikst_pkg::t_status   r_err;
    logic [KEY_BITS-1:0] r_fc;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_scnt;
    t_kind               r_kind;

    // Captured request and its match vector
    ikst_pkg::t_action   r_act;
    logic [KEY_BITS-1:0] r_key;
    logic                r_kv;
    logic                r_last;
    logic [ENTRIES-1:0]  r_match;

    // Output register
    logic                r_out_valid;
    ikst_pkg::t_status   r_res_st;
    logic [KEY_BITS-1:0] r_res_ck;
    logic                r_res_done;
    logic [CNT_W-1:0]    r_res_cnt;

    logic [ENTRIES-1:0]  cmp;
    logic [ENTRIES-1:0]  free;
    logic [ENTRIES-1:0]  sel;
    logic [ENTRIES-1:0]  oh;
    logic                place;
    logic [ENTRIES-1:0]  n_valid;
    logic [ENTRIES-1:0]  n_staged;
    ikst_pkg::t_status   n_err;
    logic [KEY_BITS-1:0] n_fc;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W-1:0]    n_scnt;
    t_kind               n_kind;
    ikst_pkg::t_status   rem_st;
    ikst_pkg::t_status   n_res_st;
    logic [KEY_BITS-1:0] n_res_ck;
    logic                n_res_done;

    // Compare the incoming key against every committed entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            cmp[i] = r_valid[i] && !r_staged[i] && (r_keys[i] == i_key[KEY_BITS-1:0]);
        end
    end

    // Pick the lowest free entry for insert, the lowest match for remove
    always_comb begin
        free = ~r_valid | ((r_kind != K_INSERT) ? r_staged : '0);
        sel  = (r_act == ikst_pkg::ACT_INSERT) ? free : r_match;
        oh   = sel & (~sel + ENTRIES'(1));
    end

    // Update the set and build the response
    always_comb begin
        n_valid    = r_valid;
        n_staged   = r_staged;
        n_err      = r_err;
        n_fc       = r_fc;
        n_count    = r_count;
        n_scnt     = r_scnt;
        n_kind     = r_kind;
        rem_st     = ikst_pkg::ST_OK;
        n_res_st   = ikst_pkg::ST_OK;
        n_res_ck   = '0;
        n_res_done = 1'b1;
        place      = 1'b0;
        unique case (r_act)
            ikst_pkg::ACT_INSERT: begin
                // drop a batch of another kind
                if (r_kind != K_INSERT) begin
                    n_valid  = r_valid & ~r_staged;
                    n_staged = '0;
                    n_err    = ikst_pkg::ST_OK;
                    n_fc     = '0;
                    n_scnt   = '0;
                end
                n_kind = K_INSERT;
                if (n_err != ikst_pkg::ST_INVALID && n_err != ikst_pkg::ST_PRESENT) begin
                    if (!r_kv) begin
                        n_err = ikst_pkg::ST_INVALID;
                    end else if (|r_match) begin
                        n_err = ikst_pkg::ST_PRESENT;
                        n_fc  = r_key;
                    end else if (n_err == ikst_pkg::ST_OK) begin
                        if (|sel) begin
                            place    = 1'b1;
                            n_valid  = n_valid | oh;
                            n_staged = n_staged | oh;
                            n_scnt   = n_scnt + CNT_W'(1);
                        end else begin
                            n_err = ikst_pkg::ST_FULL;
                        end
                    end
                end
                if (!r_last) begin
                    n_res_st   = ikst_pkg::ST_PENDING;
                    n_res_done = 1'b0;
                end else begin
                    // commit or roll back, then close the batch
                    if (n_err == ikst_pkg::ST_OK) begin
                        n_count = r_count + n_scnt;
                    end else begin
                        n_valid = n_valid & ~n_staged;
                        if (n_err == ikst_pkg::ST_PRESENT) begin
                            n_res_ck = n_fc;
                        end
                    end
                    n_res_st = n_err;
                    n_staged = '0;
                    n_scnt   = '0;
                    n_err    = ikst_pkg::ST_OK;
                    n_fc     = '0;
                    n_kind   = K_NONE;
                end
            end
            ikst_pkg::ACT_REMOVE: begin
                if (r_kind != K_REMOVE) begin
                    n_valid  = r_valid & ~r_staged;
                    n_staged = '0;
                    n_err    = ikst_pkg::ST_OK;
                    n_fc     = '0;
                    n_scnt   = '0;
                end
                n_kind = K_REMOVE;
                if (n_err != ikst_pkg::ST_OK) begin
                    rem_st = ikst_pkg::ST_SKIPPED;
                end else if (!r_kv) begin
                    rem_st = ikst_pkg::ST_INVALID;
                    n_err  = ikst_pkg::ST_INVALID;
                end else if (|sel) begin
                    n_valid = n_valid & ~oh;
                    n_count = r_count - CNT_W'(1);
                    rem_st  = ikst_pkg::ST_OK;
                end else begin
                    rem_st = ikst_pkg::ST_NOTFOUND;
                    n_err  = ikst_pkg::ST_NOTFOUND;
                end
                if (!r_last) begin
                    n_res_st   = rem_st;
                    n_res_done = 1'b0;
                end else begin
                    n_res_st = n_err;
                    n_err    = ikst_pkg::ST_OK;
                    n_fc     = '0;
                    n_kind   = K_NONE;
                end
            end
            ikst_pkg::ACT_CLEAR: begin
                n_valid  = '0;
                n_staged = '0;
                n_count  = '0;
                n_scnt   = '0;
                n_err    = ikst_pkg::ST_OK;
                n_fc     = '0;
                n_kind   = K_NONE;
            end
            ikst_pkg::ACT_UNUSED: begin
                n_res_st = ikst_pkg::ST_INVALID;
            end
        endcase
    end

    // Hold control state and the output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_staged    <= '0;
            r_err       <= ikst_pkg::ST_OK;
            r_fc        <= '0;
            r_count     <= '0;
            r_scnt      <= '0;
            r_kind      <= K_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_valid     <= n_valid;
                r_staged    <= n_staged;
                r_err       <= n_err;
                r_fc        <= n_fc;
                r_count     <= n_count;
                r_scnt      <= n_scnt;
                r_kind      <= n_kind;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request and the response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act   <= ikst_pkg::t_action'(i_action);
            r_key   <= i_key[KEY_BITS-1:0];
            r_kv    <= i_key_valid;
            r_last  <= i_last;
            r_match <= cmp;
        end
        if (i_cmd.execute) begin
            r_res_st   <= n_res_st;
            r_res_ck   <= n_res_ck;
            r_res_done <= n_res_done;
            r_res_cnt  <= n_count;
        end
    end

    // Write a staged key into its row
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.execute && place && oh[i]) begin
                r_keys[i] <= r_key;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_res_st;
    assign o_conflict_key  = ikst_pkg::KEY_W'(r_res_ck);
    assign o_done_res      = r_res_done;
    assign o_occupancy     = ikst_pkg::OCC_W'(r_res_cnt);

    `IKST_ASSERT_IMPLY(a_staged_valid, i_clk, i_rst_n, 1'b1, (r_staged & ~r_valid) == '0)
    `IKST_ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(ENTRIES))
    `IKST_ASSERT_IMPLY(a_staged_kind, i_clk, i_rst_n, r_staged != '0, r_kind == K_INSERT)

endmodule
